>>> rtl/core/thadc_pkg.sv
// Package for the thermistor ADC to temperature converter.
// Holds widths, fixed-point constants, status and register codes, and word types.
// No dependencies.
package thadc_pkg;

   // ADC scaling
   localparam int AdcBits  = 12;
   localparam int OvsBits  = 2;
   localparam int AdcW     = AdcBits + OvsBits;
   localparam int StepBits = AdcW - 13;
   localparam int RailW    = AdcW + 3;
   localparam int NdW      = RailW - 1;
   localparam int ReadW    = 14;
   localparam int LimitW   = 14;

   // configuration port
   localparam int CfgIdxW  = 4;
   localparam int CsrDataW = 40;

   // front to back queue
   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   // log2 lanes
   localparam int LogInW   = 24;
   localparam int LogIntW  = 5;
   localparam int FracBits = 28;
   localparam int LogW     = LogIntW + FracBits;
   localparam int MantW    = 31;
   localparam int LogIter  = 28;

   // Steinhart-Hart datapath
   localparam int L2W     = 36;
   localparam int L2MagW  = 34;
   localparam int LnW     = 33;
   localparam int Ln2W    = 38;
   localparam int Ln2LoW  = 19;
   localparam int Ln3W    = 43;
   localparam int CoefW   = 32;
   localparam int CoefCW  = 40;
   localparam int CLoW    = 20;
   localparam int BtW     = 59;
   localparam int RW      = 60;
   localparam int RemW    = 59;
   localparam int DivSteps = 21;
   localparam int TempW   = 20;
   localparam int TqW     = 22;
   localparam int MathStages = 7;
   localparam int PipeDepth  = 1 + LogIter + MathStages + DivSteps;

   localparam logic [FracBits-1:0] Ln2Q28 = 28'd186065279;
   localparam logic signed [L2W-1:0] SeriesUnit =
      {{(L2W - FracBits - 3){1'b0}}, 3'b100, {FracBits{1'b0}}};
   localparam logic [RemW-1:0] RemInit = {{(RemW - 48){1'b0}}, 1'b1, 47'b0};
   localparam logic signed [RW-1:0] RMin = {{(RW - 49){1'b0}}, 1'b1, 48'b0};
   localparam logic signed [TempW-1:0] TempBad       = 20'sd512000;
   localparam logic signed [TempW-1:0] TempOpen      = -20'sd69926;
   localparam logic signed [TempW-1:0] TempMax       = 20'sd524287;
   localparam logic signed [TempW-1:0] TempColdLimit = -20'sd1280;
   localparam logic signed [TqW-1:0]   AbsZeroQ      = 22'sd69926;
   localparam logic signed [TqW-1:0]   TempMaxQ      = 22'sd524287;
   localparam logic [6:0] OpenRatio = 7'd100;

   // status codes
   localparam logic [2:0] StOk       = 3'd0;
   localparam logic [2:0] StNotReady = 3'd1;
   localparam logic [2:0] StBadRef   = 3'd2;
   localparam logic [2:0] StBadGnd   = 3'd3;
   localparam logic [2:0] StOpen     = 3'd4;
   localparam logic [2:0] StShort    = 3'd5;

   // register indexes
   localparam logic [CfgIdxW-1:0] CsrSeries    = 4'd0;
   localparam logic [CfgIdxW-1:0] CsrCoefA     = 4'd1;
   localparam logic [CfgIdxW-1:0] CsrCoefB     = 4'd2;
   localparam logic [CfgIdxW-1:0] CsrCoefC     = 4'd3;
   localparam logic [CfgIdxW-1:0] CsrLowOfs    = 4'd4;
   localparam logic [CfgIdxW-1:0] CsrHighOfs   = 4'd5;
   localparam logic [CfgIdxW-1:0] CsrRailMon   = 4'd6;
   localparam logic [CfgIdxW-1:0] CsrRailLimit = 4'd7;

   typedef struct packed {
      logic [ReadW-1:0] sensor_reading;
      logic             sensor_valid;
      logic [ReadW-1:0] ref_reading;
      logic             ref_valid;
      logic [ReadW-1:0] gnd_reading;
      logic             gnd_valid;
   } req_type;

   typedef struct packed {
      logic signed [TempW-1:0] temperature;
      logic [2:0]              status;
   } rsp_type;

   typedef struct packed {
      logic [23:0]       series_resistance;
      logic [CoefW-1:0]  coef_a;
      logic [CoefW-1:0]  coef_b;
      logic [CoefCW-1:0] coef_c;
      logic [7:0]        low_offset;
      logic [7:0]        high_offset;
      logic              use_rail_monitor;
      logic [LimitW-1:0] rail_drop_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0]     status;
      logic           cold;
      logic [NdW-1:0] num;
      logic [NdW-1:0] den;
   } item_type;

   typedef struct packed {
      logic       vld;
      logic [2:0] status;
      logic       cold;
   } sb_type;

   localparam cfg_type CfgReset = '{
      series_resistance: 24'd71680,
      coef_a:            32'd707000000,
      coef_b:            32'd259000000,
      coef_c:            40'd0,
      low_offset:        8'd0,
      high_offset:       8'd0,
      use_rail_monitor:  1'b0,
      rail_drop_limit:   14'd1327
   };

endpackage

>>> rtl/core/thadc_front.sv
// Front end: configuration registers, rail checks and fault classification.
// Depends on thadc_pkg; feeds thadc_queue.
module thadc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [thadc_pkg::CfgIdxW-1:0]     csr_index,
   input  logic [thadc_pkg::CsrDataW-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  thadc_pkg::req_type                req_data,
   output logic                              push_valid,
   input  logic                              push_ready,
   output thadc_pkg::item_type               push_item,
   output thadc_pkg::cfg_type                cfg
);

   thadc_pkg::cfg_type cfg_ff, cfg_in;

   // decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            thadc_pkg::CsrSeries:    cfg_in.series_resistance = csr_wdata[23:0];
            thadc_pkg::CsrCoefA:     cfg_in.coef_a = csr_wdata[thadc_pkg::CoefW-1:0];
            thadc_pkg::CsrCoefB:     cfg_in.coef_b = csr_wdata[thadc_pkg::CoefW-1:0];
            thadc_pkg::CsrCoefC:     cfg_in.coef_c = csr_wdata[thadc_pkg::CoefCW-1:0];
            thadc_pkg::CsrLowOfs:    cfg_in.low_offset = csr_wdata[7:0];
            thadc_pkg::CsrHighOfs:   cfg_in.high_offset = csr_wdata[7:0];
            thadc_pkg::CsrRailMon:   cfg_in.use_rail_monitor = csr_wdata[0];
            thadc_pkg::CsrRailLimit: begin
               cfg_in.rail_drop_limit = csr_wdata[thadc_pkg::LimitW-1:0];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= thadc_pkg::CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   localparam int RailW = thadc_pkg::RailW;
   localparam logic signed [RailW-1:0] FullRail =
      {{(RailW - thadc_pkg::AdcW - 1){1'b0}}, 1'b1, {thadc_pkg::AdcW{1'b0}}};

   logic signed [RailW-1:0] lo_w, hi_w, t_w, rr_w, gr_w, lim_w;
   logic signed [RailW-1:0] vref_w, vgnd_w, num_w, den_w;
   logic [thadc_pkg::NdW-1:0] num_u, den_u;
   logic                      mon_w, not_ready_w, cold_w;

   // scale offsets to oversampled counts, pick rails
   assign lo_w  = {{(RailW - 8){cfg_ff.low_offset[7]}}, cfg_ff.low_offset}
                  <<< thadc_pkg::StepBits;
   assign hi_w  = {{(RailW - 8){cfg_ff.high_offset[7]}}, cfg_ff.high_offset}
                  <<< thadc_pkg::StepBits;
   assign t_w   = {{(RailW - thadc_pkg::ReadW){1'b0}}, req_data.sensor_reading};
   assign rr_w  = {{(RailW - thadc_pkg::ReadW){1'b0}}, req_data.ref_reading};
   assign gr_w  = {{(RailW - thadc_pkg::ReadW){1'b0}}, req_data.gnd_reading};
   assign lim_w = {{(RailW - thadc_pkg::LimitW){1'b0}}, cfg_ff.rail_drop_limit};
   assign mon_w = cfg_ff.use_rail_monitor;

   assign vref_w = mon_w ? (rr_w + hi_w) : (FullRail + hi_w);
   assign vgnd_w = mon_w ? (gr_w + lo_w) : lo_w;
   assign num_w  = t_w - vgnd_w;
   assign den_w  = vref_w - t_w;
   assign num_u  = num_w[thadc_pkg::NdW-1:0];
   assign den_u  = den_w[thadc_pkg::NdW-1:0];

   assign not_ready_w = !req_data.sensor_valid ||
                        (mon_w && (!req_data.ref_valid || !req_data.gnd_valid));
   assign cold_w = ({7'b0, num_u} > ({7'b0, den_u} * thadc_pkg::OpenRatio));

   // classify in priority order
   always_comb begin
      push_item.num  = num_u;
      push_item.den  = den_u;
      push_item.cold = cold_w;
      if (not_ready_w) begin
         push_item.status = thadc_pkg::StNotReady;
      end else if (mon_w && (vref_w < (FullRail - lim_w))) begin
         push_item.status = thadc_pkg::StBadRef;
      end else if (mon_w && (vgnd_w > lim_w)) begin
         push_item.status = thadc_pkg::StBadGnd;
      end else if (vref_w <= t_w) begin
         push_item.status = thadc_pkg::StOpen;
      end else if (t_w <= vgnd_w) begin
         push_item.status = thadc_pkg::StShort;
      end else begin
         push_item.status = thadc_pkg::StOk;
      end
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule

>>> rtl/core/thadc_queue.sv
// Short FIFO between the classifying front and the arithmetic back end.
// Depends on thadc_pkg.
module thadc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  thadc_pkg::item_type push_item,
   output logic                pop_valid,
   input  logic                pop,
   output thadc_pkg::item_type pop_item
);

   thadc_pkg::item_type entry_ff [thadc_pkg::QDepth];
   logic [thadc_pkg::QPtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [thadc_pkg::QCntW-1:0] count_ff;
   logic                        push_w, pop_w;

   assign push_ready = (count_ff != thadc_pkg::QCntW'(thadc_pkg::QDepth));
   assign pop_valid  = (count_ff != '0);
   assign push_w     = push_valid && push_ready;
   assign pop_w      = pop && pop_valid;
   assign pop_item   = entry_ff[rd_ptr_ff];

   // store word
   always_ff @(posedge clock) begin
      if (push_w) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_w) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_w) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push_w && !pop_w) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop_w && !push_w) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/core/thadc_log2.sv
// Pipelined log2 in Q28: leading-one stage, then one squaring step per stage.
// Depends on thadc_pkg.
module thadc_log2 (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [thadc_pkg::LogInW-1:0]   value,
   output logic [thadc_pkg::LogW-1:0]     result
);

   localparam int MantW    = thadc_pkg::MantW;
   localparam int FracBits = thadc_pkg::FracBits;
   localparam int LogIter  = thadc_pkg::LogIter;

   logic [thadc_pkg::LogInW-1:0]  x_w;
   logic [thadc_pkg::LogIntW-1:0] lead_w;
   logic [MantW-1:0]              mant_w;

   // find leading one, zero reads as one
   always_comb begin
      x_w    = (value == '0) ? thadc_pkg::LogInW'(1) : value;
      lead_w = '0;
      for (int i = 0; i < thadc_pkg::LogInW; i++) begin
         if (x_w[i]) begin
            lead_w = thadc_pkg::LogIntW'(i);
         end
      end
      mant_w = MantW'(x_w) << (thadc_pkg::LogIntW'(MantW - 1) - lead_w);
   end

   logic [thadc_pkg::LogIntW-1:0] p_ff [LogIter + 1];
   logic [FracBits-1:0]           f_ff [LogIter + 1];
   logic [MantW-1:0]              m_ff [LogIter];

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff[0] <= lead_w;
         f_ff[0] <= '0;
         m_ff[0] <= mant_w;
      end
   end

   // square the mantissa, one fraction bit per stage
   for (genvar k = 1; k <= LogIter; k++) begin : g_step
      logic [2*MantW-1:0] sq_w;
      logic [MantW:0]     sh_w;
      assign sq_w = m_ff[k-1] * m_ff[k-1];
      assign sh_w = sq_w[2*MantW-1:MantW-1];

      always_ff @(posedge clock) begin
         if (enable) begin
            p_ff[k] <= p_ff[k-1];
            f_ff[k] <= {f_ff[k-1][FracBits-2:0], sh_w[MantW]};
         end
      end

      if (k < LogIter) begin : g_mant
         always_ff @(posedge clock) begin
            if (enable) begin
               m_ff[k] <= sh_w[MantW] ? sh_w[MantW:1] : sh_w[MantW-1:0];
            end
         end
      end
   end

   assign result = {p_ff[LogIter], f_ff[LogIter]};

endmodule

>>> rtl/core/thadc_back.sv
// Back end: log2 lanes, Steinhart-Hart polynomial, reciprocal divider, output register.
// Depends on thadc_pkg and thadc_log2.
module thadc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  thadc_pkg::item_type q_item,
   output logic                q_pop,
   input  thadc_pkg::cfg_type  cfg,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output thadc_pkg::rsp_type  rsp_data
);

   localparam int FracBits = thadc_pkg::FracBits;
   localparam int LnW      = thadc_pkg::LnW;
   localparam int Ln2W     = thadc_pkg::Ln2W;
   localparam int Ln2LoW   = thadc_pkg::Ln2LoW;
   localparam int Ln3W     = thadc_pkg::Ln3W;
   localparam int L2MagW   = thadc_pkg::L2MagW;
   localparam int CoefW    = thadc_pkg::CoefW;
   localparam int CoefCW   = thadc_pkg::CoefCW;
   localparam int CLoW     = thadc_pkg::CLoW;
   localparam int BtW      = thadc_pkg::BtW;
   localparam int RW       = thadc_pkg::RW;
   localparam int RemW     = thadc_pkg::RemW;
   localparam int DivSteps = thadc_pkg::DivSteps;
   localparam int Depth    = thadc_pkg::PipeDepth;

   logic               rsp_valid_ff;
   thadc_pkg::rsp_type rsp_ff;
   logic               adv_w;

   // whole pipe moves when the output register can take a word
   assign adv_w = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv_w && q_valid;

   // log2 lanes
   logic [thadc_pkg::LogInW-1:0] ser_w, num_w, den_w;
   logic [thadc_pkg::LogW-1:0]   lg_ser, lg_num, lg_den;

   assign ser_w = (cfg.series_resistance == '0) ? thadc_pkg::LogInW'(1)
                                                : cfg.series_resistance;
   assign num_w = thadc_pkg::LogInW'(q_item.num);
   assign den_w = thadc_pkg::LogInW'(q_item.den);

   thadc_log2 u_log_ser (.clock(clock), .enable(adv_w), .value(ser_w), .result(lg_ser));
   thadc_log2 u_log_num (.clock(clock), .enable(adv_w), .value(num_w), .result(lg_num));
   thadc_log2 u_log_den (.clock(clock), .enable(adv_w), .value(den_w), .result(lg_den));

   // status and cold flag ride alongside the math
   thadc_pkg::sb_type sb_ff [Depth];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) begin
            sb_ff[i].vld <= 1'b0;
         end
      end else if (adv_w) begin
         sb_ff[0].vld    <= q_valid;
         sb_ff[0].status <= q_item.status;
         sb_ff[0].cold   <= q_item.cold;
         for (int i = 1; i < Depth; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
      end
   end

   // stage A: log2 of resistance, then sign and magnitude
   logic signed [thadc_pkg::L2W-1:0] a_l2_in, a_l2_neg_w;
   logic                             a_neg_ff;
   logic [L2MagW-1:0]                a_mag_ff;

   assign a_l2_in = $signed({3'b0, lg_ser}) - thadc_pkg::SeriesUnit
                  + $signed({3'b0, lg_num}) - $signed({3'b0, lg_den});
   assign a_l2_neg_w = -a_l2_in;

   always_ff @(posedge clock) begin
      if (adv_w) begin
         a_neg_ff <= a_l2_in[thadc_pkg::L2W-1];
         a_mag_ff <= a_l2_in[thadc_pkg::L2W-1] ? a_l2_neg_w[L2MagW-1:0]
                                               : a_l2_in[L2MagW-1:0];
      end
   end

   // stage B: ln = log2 * ln2
   logic [FracBits+L2MagW-1:0] b_prod_w;
   logic                       b_neg_ff;
   logic [LnW-1:0]             b_ln_ff;

   assign b_prod_w = {{FracBits{1'b0}}, a_mag_ff} * {{L2MagW{1'b0}}, thadc_pkg::Ln2Q28};

   always_ff @(posedge clock) begin
      if (adv_w) begin
         b_neg_ff <= a_neg_ff;
         b_ln_ff  <= b_prod_w[FracBits+LnW-1:FracBits];
      end
   end

   // stage C: ln squared and the b term
   logic [2*LnW-1:0]        c_sq_w;
   logic                    c_bneg_w;
   logic [CoefW-1:0]        c_bmag_w;
   logic [CoefW+LnW-1:0]    c_bp_w;
   logic signed [BtW-1:0]   c_bt_in, c_btpos_w;
   logic [Ln2W-1:0]         c_ln2_ff;
   logic [LnW-1:0]          c_ln_ff;
   logic                    c_neg_ff;
   logic signed [BtW-1:0]   c_bt_ff;

   assign c_sq_w    = {{LnW{1'b0}}, b_ln_ff} * {{LnW{1'b0}}, b_ln_ff};
   assign c_bneg_w  = cfg.coef_b[CoefW-1];
   assign c_bmag_w  = c_bneg_w ? (~cfg.coef_b + 1'b1) : cfg.coef_b;
   assign c_bp_w    = {{LnW{1'b0}}, c_bmag_w} * {{CoefW{1'b0}}, b_ln_ff};
   assign c_btpos_w = BtW'(c_bp_w[CoefW+LnW-1:8]);
   assign c_bt_in   = (c_bneg_w ^ b_neg_ff) ? -c_btpos_w : c_btpos_w;

   always_ff @(posedge clock) begin
      if (adv_w) begin
         c_ln2_ff <= c_sq_w[FracBits+Ln2W-1:FracBits];
         c_ln_ff  <= b_ln_ff;
         c_neg_ff <= b_neg_ff;
         c_bt_ff  <= c_bt_in;
      end
   end

   // stage D: ln cubed, split into two partial products
   localparam int DW = Ln2LoW + LnW;
   logic [DW-1:0]         d_lo_ff, d_hi_ff;
   logic                  d_neg_ff;
   logic signed [BtW-1:0] d_bt_ff;

   always_ff @(posedge clock) begin
      if (adv_w) begin
         d_lo_ff  <= {{LnW{1'b0}}, c_ln2_ff[Ln2LoW-1:0]} * {{Ln2LoW{1'b0}}, c_ln_ff};
         d_hi_ff  <= {{LnW{1'b0}}, c_ln2_ff[Ln2W-1:Ln2LoW]} * {{Ln2LoW{1'b0}}, c_ln_ff};
         d_neg_ff <= c_neg_ff;
         d_bt_ff  <= c_bt_ff;
      end
   end

   // stage E: combine partials of ln cubed
   logic [DW+Ln2LoW-1:0]  e_sum_w;
   logic [Ln3W-1:0]       e_ln3_ff;
   logic                  e_neg_ff;
   logic signed [BtW-1:0] e_bt_ff;

   assign e_sum_w = {d_hi_ff, {Ln2LoW{1'b0}}} + {{Ln2LoW{1'b0}}, d_lo_ff};

   always_ff @(posedge clock) begin
      if (adv_w) begin
         e_ln3_ff <= e_sum_w[FracBits+Ln3W-1:FracBits];
         e_neg_ff <= d_neg_ff;
         e_bt_ff  <= d_bt_ff;
      end
   end

   // stage F: c times ln cubed, split into two partial products
   localparam int FW = CLoW + Ln3W;
   logic              f_cneg_w;
   logic [CoefCW-1:0] f_cmag_w;
   logic [FW-1:0]     f_lo_ff, f_hi_ff;
   logic              f_neg_ff;
   logic signed [BtW-1:0] f_bt_ff;

   assign f_cneg_w = cfg.coef_c[CoefCW-1];
   assign f_cmag_w = f_cneg_w ? (~cfg.coef_c + 1'b1) : cfg.coef_c;

   always_ff @(posedge clock) begin
      if (adv_w) begin
         f_lo_ff  <= {{Ln3W{1'b0}}, f_cmag_w[CLoW-1:0]} * {{CLoW{1'b0}}, e_ln3_ff};
         f_hi_ff  <= {{Ln3W{1'b0}}, f_cmag_w[CoefCW-1:CLoW]} * {{CLoW{1'b0}}, e_ln3_ff};
         f_neg_ff <= f_cneg_w ^ e_neg_ff;
         f_bt_ff  <= e_bt_ff;
      end
   end

   // stage G: sum the reciprocal temperature
   logic [FW+CLoW-1:0]   g_sum_w;
   logic signed [RW-1:0] g_ctpos_w, g_ct_w, g_a_w, g_r_in, g_r_ff;

   assign g_sum_w   = {f_hi_ff, {CLoW{1'b0}}} + {{CLoW{1'b0}}, f_lo_ff};
   assign g_ctpos_w = RW'(g_sum_w[FW+CLoW-1:FracBits]);
   assign g_ct_w    = f_neg_ff ? -g_ctpos_w : g_ctpos_w;
   assign g_a_w     = {{(RW - CoefW - 20){cfg.coef_a[CoefW-1]}}, cfg.coef_a, 20'b0};
   assign g_r_in    = g_a_w + RW'(f_bt_ff) + g_ct_w;

   always_ff @(posedge clock) begin
      if (adv_w) begin
         g_r_ff <= g_r_in;
      end
   end

   // restoring divider for 2^68 / r, one quotient bit per stage
   logic [RemW-1:0]      dv_rem_ff [DivSteps];
   logic signed [RW-1:0] dv_r_ff   [DivSteps];
   logic [DivSteps-1:0]  dv_q_ff   [DivSteps];

   for (genvar j = 0; j < DivSteps; j++) begin : g_div
      logic [RemW-1:0]     rem_prev;
      logic [RW-1:0]       r_prev;
      logic [DivSteps-1:0] q_prev;
      logic [RW-1:0]       rem2_w, diff_w;
      logic                take_w;

      if (j == 0) begin : g_first
         assign rem_prev = thadc_pkg::RemInit;
         assign r_prev   = g_r_ff;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = dv_rem_ff[j-1];
         assign r_prev   = dv_r_ff[j-1];
         assign q_prev   = dv_q_ff[j-1];
      end

      assign rem2_w = {rem_prev, 1'b0};
      assign take_w = (rem2_w >= r_prev);
      assign diff_w = rem2_w - r_prev;

      always_ff @(posedge clock) begin
         if (adv_w) begin
            dv_rem_ff[j] <= take_w ? diff_w[RemW-1:0] : rem2_w[RemW-1:0];
            dv_r_ff[j]   <= r_prev;
            dv_q_ff[j]   <= {q_prev[DivSteps-2:0], take_w};
         end
      end
   end

   // final temperature, saturation and cold-open check
   thadc_pkg::sb_type              sb_last;
   logic signed [RW-1:0]           r_last;
   logic signed [thadc_pkg::TqW-1:0]   tq_w;
   logic signed [thadc_pkg::TempW-1:0] temp_in;
   logic [2:0]                     status_in;

   assign sb_last = sb_ff[Depth-1];
   assign r_last  = dv_r_ff[DivSteps-1];
   assign tq_w    = $signed({1'b0, dv_q_ff[DivSteps-1]}) - thadc_pkg::AbsZeroQ;

   always_comb begin
      status_in = sb_last.status;
      temp_in   = thadc_pkg::TempBad;
      if (sb_last.status != thadc_pkg::StOk) begin
         temp_in = (sb_last.status == thadc_pkg::StOpen) ? thadc_pkg::TempOpen
                                                         : thadc_pkg::TempBad;
      end else begin
         if (r_last[RW-1] || (r_last == '0)) begin
            temp_in = thadc_pkg::TempBad;
         end else if (r_last < thadc_pkg::RMin) begin
            temp_in = thadc_pkg::TempMax;
         end else if (tq_w > thadc_pkg::TempMaxQ) begin
            temp_in = thadc_pkg::TempMax;
         end else begin
            temp_in = tq_w[thadc_pkg::TempW-1:0];
         end
         if ((temp_in < thadc_pkg::TempColdLimit) && sb_last.cold) begin
            status_in = thadc_pkg::StOpen;
            temp_in   = thadc_pkg::TempOpen;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_w) begin
         rsp_valid_ff <= sb_last.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_w) begin
         rsp_ff.temperature <= temp_in;
         rsp_ff.status      <= status_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/thermistor_adc_to_temperature.sv
// Thermistor ADC reading to temperature (Steinhart-Hart), fixed point.
// Path: queue, 29 log2, 7 polynomial and 21 divider stages, output register; throughput one word
// per clock while rsp_ready does not stall the pipe, set by the pipelined log2 and divider.
// Reset clears the queue, all pipeline valid bits and loads the register reset values.
// Depends on thadc_pkg, thadc_front, thadc_queue, thadc_back.
module thermistor_adc_to_temperature (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  thadc_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output thadc_pkg::rsp_type             rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [thadc_pkg::CfgIdxW-1:0]  csr_index,
   input  logic [thadc_pkg::CsrDataW-1:0] csr_wdata
);

   thadc_pkg::item_type push_item, pop_item;
   thadc_pkg::cfg_type  cfg;
   logic                push_valid, push_ready, pop_valid, pop;

   // classify and hold configuration
   thadc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .cfg        (cfg)
   );

   // decouple front and back
   thadc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_item   (pop_item)
   );

   // arithmetic and output
   thadc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (pop_valid),
      .q_item    (pop_item),
      .q_pop     (pop),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/thermistor_adc_to_temperature_test.sv
// Testbench for thermistor_adc_to_temperature: random and directed readings under
// several register settings, checked against a built-in fixed-point predictor.
// Depends on thadc_pkg and the thermistor_adc_to_temperature RTL.
`timescale 1ns / 100ps

module thermistor_adc_to_temperature_test;
   import thadc_pkg::*;

   localparam logic [CfgIdxW-1:0] CsrUnused = 4'd15;
   localparam int Latency   = 58;
   localparam int IdleLimit = 2000;

   typedef struct {
      bit                 is_cfg;
      logic [CfgIdxW-1:0] idx;
      logic [CsrDataW-1:0] wdata;
      req_type            word;
   } op_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CfgIdxW-1:0]  csr_index = '0;
   logic [CsrDataW-1:0] csr_wdata = '0;

   op_type  plan[$];
   rsp_type temps_due[$];
   int      in_flight = 0;
   int      errors = 0;
   int      idle_cycles = 0;

   // predictor copy of the registers
   bit [23:0] m_series;
   longint    m_ca, m_cb, m_cc, m_lo, m_hi, m_lim;
   bit        m_mon;

   thermistor_adc_to_temperature u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // log2 in Q28: integer part from the leading one, fraction by squaring
   function automatic longint log2_q28(bit [63:0] x);
      int        p;
      bit [63:0] m;
      bit [63:0] frac;
      if (x == 0) x = 1;
      p = 0;
      while (p < 63 && (x >> (p + 1)) != 0) p++;
      m = (p >= 30) ? x >> (p - 30) : x << (30 - p);
      frac = 0;
      for (int i = 0; i < 28; i++) begin
         m = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'h8000_0000) begin
            m = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return longint'((64'(p) << 28) | frac);
   endfunction

   // signed product shifted right, truncated toward zero
   function automatic longint mul_trunc(longint a, longint b, int sh);
      bit [63:0]  ua, ub, r;
      bit [127:0] pr;
      bit         neg;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 64'(-a) : 64'(a);
      ub = (b < 0) ? 64'(-b) : 64'(b);
      pr = {64'b0, ua} * {64'b0, ub};
      r = 64'(pr >> sh);
      r[63] = 1'b0;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   function automatic void write_register(logic [CfgIdxW-1:0] idx, logic [CsrDataW-1:0] d);
      case (idx)
         CsrSeries:    m_series = d[23:0];
         CsrCoefA:     m_ca = longint'(signed'(d[31:0]));
         CsrCoefB:     m_cb = longint'(signed'(d[31:0]));
         CsrCoefC:     m_cc = longint'(signed'(d[39:0]));
         CsrLowOfs:    m_lo = longint'(signed'(d[7:0]));
         CsrHighOfs:   m_hi = longint'(signed'(d[7:0]));
         CsrRailMon:   m_mon = d[0];
         CsrRailLimit: m_lim = longint'(d[13:0]);
         default: ;
      endcase
   endfunction

   function automatic rsp_type convert_reading(req_type w);
      longint    t, vref, vgnd, num, den, l2, ln, ln2, ln3, r, temp, full, stp;
      bit [63:0] ur, q, big, ser;
      logic [2:0] st;
      rsp_type   o;
      full = 64'sd1 << AdcW;
      stp = 64'sd1 << StepBits;
      temp = 512000;
      st = StOk;
      t = longint'(w.sensor_reading);
      if (!w.sensor_valid || (m_mon && (!w.ref_valid || !w.gnd_valid))) begin
         st = StNotReady;
      end else begin
         if (m_mon) begin
            vref = longint'(w.ref_reading) + m_hi * stp;
            vgnd = longint'(w.gnd_reading) + m_lo * stp;
         end else begin
            vref = full + m_hi * stp;
            vgnd = m_lo * stp;
         end
         if (m_mon && vref < full - m_lim) st = StBadRef;
         else if (m_mon && vgnd > m_lim) st = StBadGnd;
         else if (vref <= t) begin
            st = StOpen;
            temp = -69926;
         end else if (t <= vgnd) st = StShort;
         else begin
            num = t - vgnd;
            den = vref - t;
            ser = (m_series == 0) ? 64'd1 : 64'(m_series);
            l2 = log2_q28(ser) - (64'sd4 << 28) + log2_q28(64'(num)) - log2_q28(64'(den));
            ln = mul_trunc(l2, longint'(Ln2Q28), 28);
            ln2 = mul_trunc(ln, ln, 28);
            ln3 = mul_trunc(ln2, ln, 28);
            r = m_ca * 1048576 + mul_trunc(m_cb, ln, 8) + mul_trunc(m_cc, ln3, 28);
            if (r <= 0) temp = 512000;
            else if (r < (64'sd1 << 48)) temp = 524287;
            else begin
               ur = 64'(r);
               big = 64'h4000_0000_0000_0000;
               q = (big / ur) * 64 + ((big % ur) * 64) / ur;
               temp = longint'(q) - 69926;
               if (temp > 524287) temp = 524287;
            end
            // cold and far above the series resistor: treat as open
            if (temp < -1280 && num > 100 * den) begin
               st = StOpen;
               temp = -69926;
            end
         end
      end
      o.temperature = temp[19:0];
      o.status = st;
      return o;
   endfunction

   // driver: csr writes only with nothing in flight, words in bursts with gaps
   int gap = 0, burst = 0;
   always @(posedge clock) begin
      bit take_req, take_csr, take_rsp, nreq, ncsr;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         in_flight = 0;
      end else begin
         take_req = req_valid && req_ready;
         take_csr = csr_valid && csr_ready;
         take_rsp = rsp_valid && rsp_ready;
         if (take_csr) write_register(csr_index, csr_wdata);
         if (take_req) temps_due.push_back(convert_reading(req_data));
         in_flight = in_flight + int'(take_req) - int'(take_rsp);
         nreq = req_valid && !take_req;
         ncsr = csr_valid && !take_csr;
         if (!nreq && !ncsr && plan.size() > 0) begin
            if (plan[0].is_cfg) begin
               if (in_flight == 0) begin
                  ncsr = 1'b1;
                  csr_index <= plan[0].idx;
                  csr_wdata <= plan[0].wdata;
                  void'(plan.pop_front());
               end
            end else if (gap > 0) begin
               gap--;
            end else begin
               nreq = 1'b1;
               req_data <= plan[0].word;
               void'(plan.pop_front());
               if (burst > 0) burst--;
               else begin
                  burst = $urandom_range(0, 24);
                  gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
         req_valid <= nreq;
         csr_valid <= ncsr;
      end
   end

   // monitor: stall pattern, compare against the oldest expected word, watchdog
   int stall_mode = 0, stall_count = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (temps_due.size() == 0) begin
               $error("unexpected word: temperature %0d status %0d",
                      rsp_data.temperature, rsp_data.status);
               errors++;
            end else begin
               want = temps_due.pop_front();
               if (rsp_data.temperature !== want.temperature) begin
                  $error("temperature: expected %0d, got %0d",
                         want.temperature, rsp_data.temperature);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("thermistor_adc_to_temperature: mismatch");
            $finish;
         end
      end
      stall_count++;
      if (stall_count >= 64) begin
         stall_count = 0;
         stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (stall_count % 4 == 0);
         default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   task automatic add_cfg(logic [CfgIdxW-1:0] idx, logic [CsrDataW-1:0] d);
      op_type op;
      op.is_cfg = 1'b1;
      op.idx = idx;
      op.wdata = d;
      op.word = '0;
      plan.push_back(op);
   endtask

   task automatic add_word(logic [13:0] s, bit sv, logic [13:0] rr, bit rv,
                           logic [13:0] gr, bit gv);
      op_type op;
      op.is_cfg = 1'b0;
      op.idx = '0;
      op.wdata = '0;
      op.word = '{sensor_reading: s, sensor_valid: sv, ref_reading: rr,
                  ref_valid: rv, gnd_reading: gr, gnd_valid: gv};
      plan.push_back(op);
   endtask

   task automatic write_all(logic [23:0] ser, logic [31:0] ca, logic [31:0] cb,
                            logic [39:0] cc, logic [7:0] lo, logic [7:0] hi,
                            bit mon, logic [13:0] lim);
      add_cfg(CsrSeries, 40'(ser));
      add_cfg(CsrCoefA, 40'(ca));
      add_cfg(CsrCoefB, 40'(cb));
      add_cfg(CsrCoefC, cc);
      add_cfg(CsrLowOfs, 40'(lo));
      add_cfg(CsrHighOfs, 40'(hi));
      add_cfg(CsrRailMon, 40'(mon));
      add_cfg(CsrRailLimit, 40'(lim));
   endtask

   // extremes, not ready, open, short and rail faults
   task automatic add_directed();
      add_word(14'd0, 1, 14'd16383, 1, 14'd0, 1);
      add_word(14'd16383, 1, 14'd16383, 1, 14'd0, 1);
      add_word(14'd1, 1, 14'd16383, 1, 14'd0, 1);
      add_word(14'd16382, 1, 14'd16383, 1, 14'd0, 1);
      add_word(14'd8192, 1, 14'd16383, 1, 14'd0, 1);
      add_word(14'd8192, 0, 14'd16383, 1, 14'd0, 1);
      add_word(14'd8192, 1, 14'd16383, 0, 14'd0, 1);
      add_word(14'd8192, 1, 14'd16383, 1, 14'd0, 0);
      add_word(14'd8192, 1, 14'd0, 1, 14'd0, 1);
      add_word(14'd8192, 1, 14'd16383, 1, 14'd16383, 1);
      add_word(14'd16300, 1, 14'd16383, 1, 14'd10, 1);
      add_word(14'd16370, 1, 14'd16383, 1, 14'd10, 1);
      add_word(14'd30, 1, 14'd16383, 1, 14'd10, 1);
      add_word(14'd4000, 1, 14'd15100, 1, 14'd1300, 1);
      add_word(14'd12000, 1, 14'd16383, 1, 14'd1, 1);
   endtask

   task automatic add_random(int n);
      int          kind;
      logic [13:0] s, rr, gr;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 9);
         rr = 14'd16383 - 14'($urandom_range(0, 1500));
         gr = 14'($urandom_range(0, 1500));
         s = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(gr, rr));
         if (kind == 0)
            add_word(14'($urandom), 1'($urandom_range(0, 1)), 14'($urandom),
                     1'($urandom_range(0, 1)), 14'($urandom), 1'($urandom_range(0, 1)));
         else if (kind == 1)
            add_word(s, 1'($urandom_range(0, 1)), rr, 1'($urandom_range(0, 1)),
                     gr, 1'($urandom_range(0, 1)));
         else
            add_word(s, 1, rr, 1, gr, 1);
      end
   endtask

   initial begin
      bit done;
      m_series = 24'd71680;
      m_ca = 707000000;
      m_cb = 259000000;
      m_cc = 0;
      m_lo = 0;
      m_hi = 0;
      m_mon = 1'b0;
      m_lim = 1327;

      // reset values first
      add_directed();
      add_random(170);
      // rail monitor on
      write_all(24'd71680, 32'd707000000, 32'd259000000, 40'd0, 8'd0, 8'd0, 1, 14'd1327);
      add_directed();
      add_random(170);
      write_all(24'd71680, 32'd707000000, 32'd259000000, 40'd0, 8'h80, 8'h7F, 1, 14'd0);
      add_directed();
      add_random(170);
      write_all(24'd0, 32'd707000000, 32'd259000000, 40'd0, 8'h7F, 8'h80, 0, 14'd16383);
      add_random(170);
      write_all(24'd16777215, 32'h7FFF_FFFF, 32'h8000_0000, 40'h7F_FFFF_FFFF,
                8'd0, 8'd0, 0, 14'd1327);
      add_random(170);
      write_all(24'd16, 32'h8000_0000, 32'h7FFF_FFFF, 40'h80_0000_0000,
                8'd3, 8'hFD, 1, 14'd2000);
      add_random(170);
      // realistic cubic term, and a write to an unmapped index
      write_all(24'd160000, 32'd650000000, 32'd260000000, 40'd100000000000,
                8'($urandom), 8'($urandom), 1, 14'd1500);
      add_cfg(CsrUnused, 40'hFF_FFFF_FFFF);
      add_random(170);
      write_all(24'($urandom_range(16, 16777215)), $urandom, $urandom,
                {8'($urandom), 32'($urandom)}, 8'($urandom), 8'($urandom),
                1'($urandom_range(0, 1)), 14'($urandom));
      add_random(170);
      write_all(24'd71680, 32'd707000000, 32'd259000000, 40'd0, 8'd0, 8'd0, 0, 14'd1327);
      add_random(170);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain, then let the pipeline settle
      done = 1'b0;
      while (!done) begin
         @(posedge clock);
         done = plan.size() == 0 && !req_valid && !csr_valid && in_flight == 0;
      end
      repeat (Latency + 20) @(posedge clock);
      if (temps_due.size() != 0) begin
         $error("%0d expected words never arrived", temps_due.size());
         errors++;
      end
      if (errors == 0)
         $display("thermistor_adc_to_temperature: match");
      else
         $display("thermistor_adc_to_temperature: mismatch");
      $finish;
   end

endmodule
